>>> hdl/dc_motor_ramp_reverse_drive_defines.svh
// ----------------------------------------------------------------------------
// DC motor ramp/reverse drive: assertion macros
// Shared concurrent assertion macros. They are empty in synthesis builds.
// ----------------------------------------------------------------------------
`ifndef DC_MOTOR_RAMP_REVERSE_DRIVE_DEFINES_SVH
`define DC_MOTOR_RAMP_REVERSE_DRIVE_DEFINES_SVH

`ifndef SYNTHESIS

// Checked outside reset only.
`define DCMR_ASSERT(label, clk, rst, prop) \
  label: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("dcmr assertion failed");

// Checked on every clock edge, reset included.
`define DCMR_ASSERT_ALWAYS(label, clk, prop) \
  label: assert property (@(posedge clk) prop) \
    else $error("dcmr assertion failed");

`else

`define DCMR_ASSERT(label, clk, rst, prop)
`define DCMR_ASSERT_ALWAYS(label, clk, prop)

`endif

`endif

>>> hdl/dcmr_pkg.sv
// ----------------------------------------------------------------------------
// DC motor ramp/reverse drive package
// Widths, codes and payload types shared by the drive modules.
// ----------------------------------------------------------------------------
package dcmr_pkg;

  localparam int LEVEL_W   = 7;
  localparam int HOLD_W    = 16;
  localparam int RATIO_W   = 11;
  localparam int REPORT_W  = 10;
  localparam int ACTION_W  = 3;
  localparam int MODE_W    = 2;

  localparam int MAX_LEVEL_DEF = 100;

  localparam logic [HOLD_W-1:0] BUSY_LIMIT_RESET = 16'd10;

  // Level is reported in tenths; ratio / 10 is done as (ratio * 3277) >> 15,
  // which is exact for every 11-bit ratio.
  localparam int RATIO_SCALE = 10;
  localparam int RECIP_10    = 3277;
  localparam int RECIP_SHIFT = 15;
  localparam int PROD_W      = RATIO_W + 12;

  localparam logic [REPORT_W-1:0] REPORT_SAT = '1;

  // Drive modes, as reported.
  localparam logic [MODE_W-1:0] MODE_STOP = 2'd0;
  localparam logic [MODE_W-1:0] MODE_FWD  = 2'd1;
  localparam logic [MODE_W-1:0] MODE_BACK = 2'd2;

  // Command codes.
  localparam logic [ACTION_W-1:0] ACT_NONE  = 3'd0;
  localparam logic [ACTION_W-1:0] ACT_STOP  = 3'd1;
  localparam logic [ACTION_W-1:0] ACT_FWD   = 3'd2;
  localparam logic [ACTION_W-1:0] ACT_BACK  = 3'd3;
  localparam logic [ACTION_W-1:0] ACT_RATIO = 3'd4;

  // Bridge pin patterns: bit 0 is pin a, bit 1 is pin b.
  localparam logic [1:0] PINS_OFF  = 2'b00;
  localparam logic [1:0] PINS_FWD  = 2'b01;
  localparam logic [1:0] PINS_BACK = 2'b10;

  typedef struct packed {
    logic [ACTION_W-1:0] action;
    logic [RATIO_W-1:0]  ratio_value;
  } dcmr_in_t;

  typedef struct packed {
    logic [REPORT_W-1:0] reported_ratio;
    logic [MODE_W-1:0]   reported_mode;
    logic                bridge_a;
    logic                bridge_b;
    logic                pwm_out;
  } dcmr_out_t;

endpackage

>>> hdl/dc_motor_ramp_reverse_drive.sv
// ----------------------------------------------------------------------------
// DC motor ramp/reverse drive, top level
// Ramped duty level with safe reversal, bridge pin control and PWM output.
// ----------------------------------------------------------------------------
//
//   Channel  Direction  Handshake            Payload
//   cmd      in         cmd_valid/cmd_stall  dcmr_in_t  (action, ratio_value)
//   sts      out        sts_valid/sts_stall  dcmr_out_t (status and pin levels)
//   cfg      in         cfg_we               cfg_wdata  (busy_limit)
//
// Each request is one control tick. It passes from the input register to the
// output register, and one request is taken every cycle while sts is not
// stalled. The tick logic in the core (ramp compares, small multiplies by ten
// and by the reciprocal of ten) sets the cycle time.
// Reset (rst, synchronous) empties both registers and restores the drive
// state and busy_limit to 10. A stall on sts holds the output register; the
// input register then holds its request and cmd_stall rises once it is full.
// ----------------------------------------------------------------------------
module dc_motor_ramp_reverse_drive
  import dcmr_pkg::*;
#(
  parameter int MaxLevel = MAX_LEVEL_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              cmd_valid,
  output logic              cmd_stall,
  input  dcmr_in_t          cmd_data,
  output logic              sts_valid,
  input  logic              sts_stall,
  output dcmr_out_t         sts_data,
  input  logic              cfg_we,
  input  logic [HOLD_W-1:0] cfg_wdata
);

  // Input register: holds one request until the core can apply it.
  logic      in_full;
  dcmr_in_t  in_item;

  // Output register: holds one result until the consumer takes it.
  logic      out_full;
  dcmr_out_t out_item;

  logic [HOLD_W-1:0] busy_limit;

  dcmr_out_t tick_result;
  logic      advance;

  // A request moves through the core whenever the output register is free or
  // is being emptied in this same cycle. The core state updates only then,
  // so a stalled request is applied exactly once.
  assign advance   = in_full && (!out_full || !sts_stall);
  assign cmd_stall = in_full && !advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else if (!cmd_stall) begin
      in_full <= cmd_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd_valid && !cmd_stall) begin
      in_item <= cmd_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_full <= 1'b0;
    end else if (advance) begin
      out_full <= 1'b1;
    end else if (!sts_stall) begin
      out_full <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_item <= tick_result;
    end
  end

  // Sole config register; user writes must come only while idle, unchecked.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy_limit <= BUSY_LIMIT_RESET;
    end else if (cfg_we) begin
      busy_limit <= cfg_wdata;
    end
  end

  dcmr_core #(
    .MaxLevel (MaxLevel)
  ) u_core (
    .clk        (clk),
    .rst        (rst),
    .en         (advance),
    .item       (in_item),
    .busy_limit (busy_limit),
    .result     (tick_result)
  );

  assign sts_valid = out_full;
  assign sts_data  = out_item;

endmodule

>>> hdl/dcmr_core.sv
// ----------------------------------------------------------------------------
// DC motor ramp/reverse drive: tick core
// Holds the drive state and applies one control tick per enable.
// ----------------------------------------------------------------------------
`include "dc_motor_ramp_reverse_drive_defines.svh"

module dcmr_core
  import dcmr_pkg::*;
#(
  parameter int MaxLevel = MAX_LEVEL_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              en,
  input  dcmr_in_t          item,
  input  logic [HOLD_W-1:0] busy_limit,
  output dcmr_out_t         result
);

  localparam logic [LEVEL_W-1:0] LevelMax  = LEVEL_W'(MaxLevel);
  localparam logic [LEVEL_W-1:0] PhaseLast = LEVEL_W'(MaxLevel - 1);
  localparam logic [RATIO_W-1:0] RatioMax  = RATIO_W'(MaxLevel * RATIO_SCALE);

  logic [MODE_W-1:0]  mode, mode_next;
  logic [MODE_W-1:0]  previous_mode, previous_mode_next;
  logic [LEVEL_W-1:0] level, level_next;
  logic [LEVEL_W-1:0] target_level, target_level_next;
  logic [HOLD_W-1:0]  hold_count, hold_count_next;
  logic [LEVEL_W-1:0] pwm_phase, pwm_phase_next;
  logic [1:0]         bridge_pins, bridge_pins_next;

  logic [MODE_W-1:0]  other_mode;
  logic [1:0]         dir_pins;
  logic               hold_busy;
  logic [PROD_W-1:0]  ratio_prod;
  logic [RATIO_W-1:0] report_wide;
  logic               pwm;

  assign hold_busy   = hold_count < busy_limit;
  assign ratio_prod  = PROD_W'(item.ratio_value) * PROD_W'(RECIP_10);
  assign report_wide = RATIO_W'(level) * RATIO_W'(RATIO_SCALE);
  assign other_mode  = (mode == MODE_FWD) ? MODE_BACK : MODE_FWD;
  assign dir_pins    = (mode == MODE_FWD) ? PINS_FWD : PINS_BACK;

  always_comb begin
    mode_next          = mode;
    previous_mode_next = previous_mode;
    level_next         = level;
    target_level_next  = target_level;
    hold_count_next    = hold_count;
    bridge_pins_next   = bridge_pins;

    // Drive update.
    case (mode)
      MODE_FWD, MODE_BACK: begin
        if (previous_mode == other_mode && level != '0) begin
          // Reversal still ramping down; the bridge keeps its old pattern.
          if (hold_busy) begin
            hold_count_next = hold_count + 1'b1;
          end else begin
            hold_count_next = '0;
            level_next      = level - 1'b1;
          end
        end else begin
          // A finished reversal switches the bridge and ramps in the same tick.
          if (previous_mode == other_mode) begin
            previous_mode_next = mode;
          end
          bridge_pins_next = dir_pins;
          if (level < target_level) begin
            if (hold_busy) begin
              hold_count_next = hold_count + 1'b1;
            end else begin
              hold_count_next = '0;
              level_next      = level + 1'b1;
            end
          end else if (level > target_level) begin
            if (hold_busy) begin
              hold_count_next = hold_count + 1'b1;
            end else begin
              hold_count_next = '0;
              level_next      = level - 1'b1;
            end
          end
        end
      end
      default: begin
        bridge_pins_next = PINS_OFF;
        level_next       = '0;
        hold_count_next  = '0;
      end
    endcase

    // Command, applied after the drive update.
    case (item.action)
      ACT_STOP: begin
        previous_mode_next = mode_next;
        mode_next          = MODE_STOP;
      end
      ACT_FWD: begin
        if (!(mode_next == MODE_BACK && previous_mode_next == MODE_FWD)) begin
          if (mode_next == MODE_BACK) begin
            target_level_next = level_next;
          end
          previous_mode_next = mode_next;
          mode_next          = MODE_FWD;
        end
      end
      ACT_BACK: begin
        if (!(mode_next == MODE_FWD && previous_mode_next == MODE_BACK)) begin
          if (mode_next == MODE_FWD) begin
            target_level_next = level_next;
          end
          previous_mode_next = mode_next;
          mode_next          = MODE_BACK;
        end
      end
      ACT_RATIO: begin
        if (item.ratio_value <= RatioMax) begin
          target_level_next = ratio_prod[RECIP_SHIFT +: LEVEL_W];
        end
      end
      default: begin
      end
    endcase
  end

  assign pwm            = pwm_phase < level_next;
  assign pwm_phase_next = (pwm_phase == PhaseLast) ? '0 : pwm_phase + 1'b1;

  always_comb begin
    result.reported_ratio = (report_wide > RATIO_W'(REPORT_SAT)) ?
                            REPORT_SAT : report_wide[REPORT_W-1:0];
    result.reported_mode  = mode;
    result.bridge_a       = bridge_pins_next[0];
    result.bridge_b       = bridge_pins_next[1];
    result.pwm_out        = pwm;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode          <= MODE_STOP;
      previous_mode <= MODE_STOP;
      level         <= '0;
      target_level  <= '0;
      hold_count    <= '0;
      pwm_phase     <= '0;
      bridge_pins   <= PINS_OFF;
    end else if (en) begin
      mode          <= mode_next;
      previous_mode <= previous_mode_next;
      level         <= level_next;
      target_level  <= target_level_next;
      hold_count    <= hold_count_next;
      pwm_phase     <= pwm_phase_next;
      bridge_pins   <= bridge_pins_next;
    end
  end

  `DCMR_ASSERT(a_level_bound, clk, rst, level <= LevelMax)
  `DCMR_ASSERT(a_phase_bound, clk, rst, pwm_phase <= PhaseLast)
  `DCMR_ASSERT(a_pins_exclusive, clk, rst, bridge_pins != 2'b11)
  `DCMR_ASSERT(a_stop_clears, clk, rst, en && mode == MODE_STOP |=> level == '0)
  `DCMR_ASSERT_ALWAYS(a_hold_on_idle, clk, !rst && !en |=> $stable(level))

endmodule
